### src/idea_block_encrypt_defines.svh
// Assertion macros used by the checker file.
`ifndef IDEA_BLOCK_ENCRYPT_DEFINES_SVH
`define IDEA_BLOCK_ENCRYPT_DEFINES_SVH

// Property checked while out of reset.
`define IDEA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define IDEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/idea_pkg.sv
// Types, constants and arithmetic helpers for the IDEA encryption pipeline.
package idea_pkg;

  localparam int ROUNDS    = 8;
  localparam int WORD_W    = 16;
  localparam int BLK_W     = 64;
  localparam int KEY_W     = 128;
  localparam int KEY_ROT   = 25;
  localparam int RND_KEYS  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 2 * WORD_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef word_t [RND_KEYS-1:0] rkeys_t;
  typedef word_t [3:0]          okeys_t;

  // Full product of two operands, word value 0 standing for 65536.
  function automatic prod_t mul_full(word_t a, word_t b);
    logic [WORD_W:0]     x;
    logic [WORD_W:0]     y;
    logic [2*WORD_W+1:0] p;
    x = {~|a, a};
    y = {~|b, b};
    p = x * y;
    return p[PROD_W-1:0];
  endfunction

  // Reduce a product mod 65537: lo - hi, wrapped; 65536 comes out as 0.
  function automatic word_t mul_red(prod_t p);
    logic [WORD_W+1:0] d;
    d = {2'b00, p[WORD_W-1:0]} - {1'b0, p[PROD_W-1:WORD_W]};
    if (d[WORD_W+1]) begin
      d = d + 18'd65537;
    end
    return d[WORD_W-1:0];
  endfunction

  // Subkey idx: slice of the key rotated left by 25 per eight subkeys.
  function automatic word_t subkey(key_t key, int idx);
    int   rot;
    int   slot;
    key_t rk;
    rot  = ((idx >> 3) * KEY_ROT) & (KEY_W - 1);
    slot = idx & 7;
    rk   = (key << rot) | (key >> (KEY_W - rot));
    return rk[KEY_W-1-WORD_W*slot -: WORD_W];
  endfunction

endpackage

### src/idea_rnd_cell.sv
// One IDEA round as a four-stage pipeline cell.
module idea_rnd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  idea_pkg::blk_t  up_w,
  input  idea_pkg::rkeys_t sk,
  output logic            dn_valid,
  input  logic            dn_ready,
  output idea_pkg::blk_t  dn_w
);

  logic [3:0] v_r;
  logic [3:0] rdy;

  idea_pkg::prod_t p1_r, p4_r, pt0_r, pt1_r;
  idea_pkg::word_t a2_r, a3_r;
  idea_pkg::word_t x1_r, x2_r, x3_r, x4_r;
  idea_pkg::word_t y1_r, y2_r, y3_r, y4_r, t0_r;
  idea_pkg::blk_t  o_r;

  idea_pkg::word_t m1, m4, t0, t1a, t1, t0b;

  always_comb begin
    rdy[3] = !v_r[3] || dn_ready;
    rdy[2] = !v_r[2] || rdy[3];
    rdy[1] = !v_r[1] || rdy[2];
    rdy[0] = !v_r[0] || rdy[1];
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[3];
  assign dn_w     = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  always_comb begin
    m1  = idea_pkg::mul_red(p1_r);
    m4  = idea_pkg::mul_red(p4_r);
    t0  = idea_pkg::mul_red(pt0_r);
    t1a = (x2_r ^ x4_r) + t0;
    t1  = idea_pkg::mul_red(pt1_r);
    t0b = t1 + t0_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r <= idea_pkg::mul_full(up_w[63:48], sk[0]);
      a2_r <= up_w[47:32] + sk[1];
      a3_r <= up_w[31:16] + sk[2];
      p4_r <= idea_pkg::mul_full(up_w[15:0], sk[3]);
    end
    if (rdy[1]) begin
      x1_r  <= m1;
      x2_r  <= a2_r;
      x3_r  <= a3_r;
      x4_r  <= m4;
      pt0_r <= idea_pkg::mul_full(m1 ^ a3_r, sk[4]);
    end
    if (rdy[2]) begin
      y1_r  <= x1_r;
      y2_r  <= x2_r;
      y3_r  <= x3_r;
      y4_r  <= x4_r;
      t0_r  <= t0;
      pt1_r <= idea_pkg::mul_full(t1a, sk[5]);
    end
    if (rdy[3]) begin
      o_r <= {y1_r ^ t1, y2_r ^ t0b, y3_r ^ t1, y4_r ^ t0b};
    end
  end

endmodule

### src/idea_out_cell.sv
// Output transformation as a two-stage pipeline cell.
module idea_out_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  idea_pkg::blk_t   up_w,
  input  idea_pkg::okeys_t sk,
  output logic             dn_valid,
  input  logic             dn_ready,
  output idea_pkg::blk_t   dn_w
);

  logic [1:0] v_r;
  logic [1:0] rdy;

  idea_pkg::prod_t p1_r, p4_r;
  idea_pkg::word_t a2_r, a3_r;
  idea_pkg::blk_t  o_r;

  always_comb begin
    rdy[1] = !v_r[1] || dn_ready;
    rdy[0] = !v_r[0] || rdy[1];
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[1];
  assign dn_w     = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r <= idea_pkg::mul_full(up_w[63:48], sk[0]);
      a2_r <= up_w[47:32] + sk[1];
      a3_r <= up_w[31:16] + sk[2];
      p4_r <= idea_pkg::mul_full(up_w[15:0], sk[3]);
    end
    if (rdy[1]) begin
      o_r <= {idea_pkg::mul_red(p1_r), a2_r, a3_r, idea_pkg::mul_red(p4_r)};
    end
  end

endmodule

### src/idea_block_encrypt.sv
// IDEA encryption top level: key registers and the chain of round cells.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_ready  in_plaintext[63:0]
//   out      out  out_valid/out_ready out_ciphertext[63:0]
//   cfg      in   cfg_we             cfg_index[0:0], cfg_wdata[63:0]
//
// One block per cycle while out_ready is held high; the depth of each
// round cell is set by the three dependent mod-65537 multiplies of
// each round, each with a register after it.
// Synchronous reset clears the key and all stage valid bits.
// Each stage holds while its successor is full and stalled; empty stages
// keep filling, so in_ready drops only when every stage holds an item.
module idea_block_encrypt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [63:0]                       in_plaintext,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [63:0]                       out_ciphertext,
  input  logic                              cfg_we,
  input  logic [idea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                       cfg_wdata
);

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  idea_pkg::key_t key;

  logic           ch_valid [idea_pkg::ROUNDS+1];
  logic           ch_ready [idea_pkg::ROUNDS+1];
  idea_pkg::blk_t ch_w     [idea_pkg::ROUNDS+1];

  idea_pkg::okeys_t ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        idea_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        idea_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key = {key_high_r, key_low_r};

  assign ch_valid[0] = in_valid;
  assign in_ready    = ch_ready[0];
  assign ch_w[0]     = in_plaintext;

  for (genvar r = 0; r < idea_pkg::ROUNDS; r++) begin : g_rnd
    idea_pkg::rkeys_t rk;
    idea_pkg::blk_t   win;

    for (genvar j = 0; j < idea_pkg::RND_KEYS; j++) begin : g_key
      assign rk[j] = idea_pkg::subkey(key, idea_pkg::RND_KEYS * r + j);
    end

    // inner words swap between rounds
    if (r == 0) begin : g_first
      assign win = ch_w[r];
    end else begin : g_swap
      assign win = {ch_w[r][63:48], ch_w[r][31:16], ch_w[r][47:32], ch_w[r][15:0]};
    end

    idea_rnd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[r]),
      .up_ready (ch_ready[r]),
      .up_w     (win),
      .sk       (rk),
      .dn_valid (ch_valid[r+1]),
      .dn_ready (ch_ready[r+1]),
      .dn_w     (ch_w[r+1])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_okey
    assign ok[j] = idea_pkg::subkey(key, idea_pkg::RND_KEYS * idea_pkg::ROUNDS + j);
  end

  idea_out_cell u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ch_valid[idea_pkg::ROUNDS]),
    .up_ready (ch_ready[idea_pkg::ROUNDS]),
    .up_w     (ch_w[idea_pkg::ROUNDS]),
    .sk       (ok),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_w     (out_ciphertext)
  );

endmodule

### src/idea_chk.sv
// Port-level checks for the IDEA encryption block, bound to the top level.
`include "idea_block_encrypt_defines.svh"

module idea_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_ciphertext
);

  `IDEA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_ciphertext), "result changed while stalled")
  `IDEA_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")
  `IDEA_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind idea_block_encrypt idea_chk u_chk (.*);
